[sv/fpgc_pkg.sv]
`timescale 1ns / 1ps
package fpgc_pkg;

	localparam int MAP_SIDE_MAX    = 1024;
	localparam int MAP_AW          = 10;
	localparam int HALF_WINDOW_MAX = 32;
	localparam int FRAC_BITS       = 4;
	localparam int SUB_BITS        = FRAC_BITS + 1;
	localparam int ANGLE_BITS      = 16;
	localparam int CORDIC_STEPS    = 20;
	localparam int CW              = 36;
	localparam int QW              = 15;
	localparam int TRIG_W          = 18;
	localparam logic signed [CW-1:0] CORDIC_X0 = 36'sd652032874;

	typedef enum logic [1:0] {
		REQ_WRITE = 2'd0,
		REQ_SEGMENT = 2'd1,
		REQ_POSE = 2'd2,
		REQ_NONE = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		REG_MAP_WIDTH = 3'd0,
		REG_MAP_HEIGHT = 3'd1,
		REG_HALF_WINDOW = 3'd2,
		REG_LENGTH_LIMIT = 3'd3,
		REG_WIDTH_LIMIT = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic              en;
		logic [MAP_AW-1:0] x;
		logic [MAP_AW-1:0] y;
		logic              val;
	} map_wr_t;

	typedef struct packed {
		logic [10:0] w_eff;
		logic [10:0] h_eff;
		logic [10:0] span;
		logic [15:0] lx;
		logic [15:0] ly;
	} scan_cfg_t;

	typedef struct packed {
		logic [QW-1:0]            qx;
		logic [QW-1:0]            qy;
		logic signed [TRIG_W-1:0] c;
		logic signed [TRIG_W-1:0] s;
	} scan_req_t;

	typedef struct packed {
		logic done;
		logic hit;
	} scan_stat_t;

	// arctangent of 2^-k, full turn = 2^32
	function automatic logic [29:0] turn_atan(input logic [4:0] k);
		logic [29:0] v;
		case (k)
			5'd0: v = 30'h20000000;
			5'd1: v = 30'h12E4051E;
			5'd2: v = 30'h09FB385B;
			5'd3: v = 30'h051111D4;
			5'd4: v = 30'h028B0D43;
			5'd5: v = 30'h0145D7E1;
			5'd6: v = 30'h00A2F61E;
			5'd7: v = 30'h00517C55;
			5'd8: v = 30'h0028BE53;
			5'd9: v = 30'h00145F2F;
			5'd10: v = 30'h000A2F98;
			5'd11: v = 30'h000517CC;
			5'd12: v = 30'h00028BE6;
			5'd13: v = 30'h000145F3;
			5'd14: v = 30'h0000A2FA;
			5'd15: v = 30'h0000517D;
			5'd16: v = 30'h000028BE;
			5'd17: v = 30'h0000145F;
			5'd18: v = 30'h00000A30;
			5'd19: v = 30'h00000518;
			default: v = 30'h0;
		endcase
		return v;
	endfunction

endpackage

[sv/fpgc_in_if.sv]
`timescale 1ns / 1ps
interface fpgc_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [9:0]  cell_x;
	logic [9:0]  cell_y;
	logic        cell_blocked;
	logic [13:0] pos_x;
	logic [13:0] pos_y;
	logic [13:0] prev_x;
	logic [13:0] prev_y;
	logic        has_prev;
	logic [15:0] heading;

	modport source (output valid, req_type, cell_x, cell_y, cell_blocked, pos_x, pos_y,
		prev_x, prev_y, has_prev, heading, input ready);
	modport sink (input valid, req_type, cell_x, cell_y, cell_blocked, pos_x, pos_y,
		prev_x, prev_y, has_prev, heading, output ready);
endinterface

[sv/fpgc_out_if.sv]
`timescale 1ns / 1ps
interface fpgc_out_if;
	logic valid;
	logic ready;
	logic clear;
	logic midpoint_hit;

	modport source (output valid, clear, midpoint_hit, input ready);
	modport sink (input valid, clear, midpoint_hit, output ready);
endinterface

[sv/fpgc_cordic.sv]
`timescale 1ns / 1ps
module fpgc_cordic (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic                             mode_rot,
	input  logic signed [fpgc_pkg::CW-1:0]   x0,
	input  logic signed [fpgc_pkg::CW-1:0]   y0,
	input  logic signed [fpgc_pkg::CW-1:0]   z0,
	output logic                             done,
	output logic signed [fpgc_pkg::CW-1:0]   x,
	output logic signed [fpgc_pkg::CW-1:0]   y,
	output logic signed [fpgc_pkg::CW-1:0]   z
);
	import fpgc_pkg::*;

	logic signed [CW-1:0] x_q, y_q, z_q;
	logic [4:0]           k_q;
	logic                 busy_q, mode_q, done_q;
	logic signed [CW-1:0] xs, ys, at;
	logic                 up;

	// one micro-rotation per cycle; both modes share the same add/sub pair
	always_comb begin
		xs = x_q >>> k_q;
		ys = y_q >>> k_q;
		at = $signed(CW'(turn_atan(k_q)));
		up = mode_q ? !z_q[CW-1] : !(y_q > 0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			k_q    <= '0;
			mode_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				k_q    <= '0;
				mode_q <= mode_rot;
			end else if (busy_q) begin
				if (k_q == 5'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				k_q <= k_q + 5'd1;
			end
		end
	end

	// hold the vector; load on start, rotate while busy
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x0;
			y_q <= y0;
			z_q <= z0;
		end else if (busy_q) begin
			if (up) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	assign done = done_q;
	assign x = x_q;
	assign y = y_q;
	assign z = z_q;
endmodule

[sv/fpgc_scan.sv]
`timescale 1ns / 1ps
module fpgc_scan (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fpgc_pkg::map_wr_t     wr,
	input  fpgc_pkg::scan_cfg_t   cfg,
	input  logic                  start,
	input  fpgc_pkg::scan_req_t   req,
	output fpgc_pkg::scan_stat_t  stat
);
	import fpgc_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_BOUNDS, S_RUN, S_DRAIN} state_t;

	logic occ_mem [MAP_SIDE_MAX*MAP_SIDE_MAX];

	state_t            state_q;
	logic [MAP_AW-1:0] lox_q, hix_q, loy_q, hiy_q, ix_q, jy_q;
	logic              hit_q, done_q;
	logic              v_s1, bit_s1, v_s2;
	logic [MAP_AW-1:0] ix_s1, jy_s1;
	logic signed [34:0] pxc_s2, pys_s2, pyc_s2, pxs_s2;

	logic [MAP_AW-1:0] lox, loy;
	logic [10:0]       hix_raw, hiy_raw, hix, hiy;
	logic              empty;
	logic signed [34:0] dx, dy, cw, sw;
	logic signed [35:0] nx, ny, anx, any_v, lxw, lyw;
	logic              hit_now;

	// clamp the window to the map
	always_comb begin
		lox = (req.qx < QW'(cfg.span)) ? '0 : MAP_AW'((req.qx - QW'(cfg.span)) >> SUB_BITS);
		loy = (req.qy < QW'(cfg.span)) ? '0 : MAP_AW'((req.qy - QW'(cfg.span)) >> SUB_BITS);
		hix_raw = 11'(({1'b0, req.qx} + 16'(cfg.span)) >> SUB_BITS);
		hiy_raw = 11'(({1'b0, req.qy} + 16'(cfg.span)) >> SUB_BITS);
		hix = (hix_raw > cfg.w_eff - 11'd1) ? cfg.w_eff - 11'd1 : hix_raw;
		hiy = (hiy_raw > cfg.h_eff - 11'd1) ? cfg.h_eff - 11'd1 : hiy_raw;
		empty = (cfg.w_eff == '0) || (cfg.h_eff == '0) ||
			({1'b0, lox} > hix) || ({1'b0, loy} > hiy);
	end

	// robot-frame test of the cell whose products sit in the multiply stage
	always_comb begin
		dx = $signed(35'({ix_s1, SUB_BITS'(0)})) - $signed(35'(req.qx));
		dy = $signed(35'({jy_s1, SUB_BITS'(0)})) - $signed(35'(req.qy));
		cw = 35'(req.c);
		sw = 35'(req.s);
		nx = 36'(pxc_s2) + 36'(pys_s2);
		ny = 36'(pyc_s2) - 36'(pxs_s2);
		anx = nx[35] ? -nx : nx;
		any_v = ny[35] ? -ny : ny;
		lxw = $signed(36'({cfg.lx, 17'b0}));
		lyw = $signed(36'({cfg.ly, 17'b0}));
		hit_now = v_s2 && (anx < lxw) && (any_v < lyw);
	end

	// sequence the window walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			hit_q   <= 1'b0;
			done_q  <= 1'b0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			v_s1   <= 1'b0;
			v_s2   <= v_s1 && bit_s1;
			if (hit_now)
				hit_q <= 1'b1;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						hit_q   <= 1'b0;
						state_q <= S_BOUNDS;
					end
				end
				S_BOUNDS: begin
					if (empty) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					if (hit_q) begin
						state_q <= S_DRAIN;
					end else begin
						v_s1 <= 1'b1;
						if (jy_q == hiy_q && ix_q == hix_q)
							state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (!v_s1 && !v_s2) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// walk columns outer, rows inner
	always_ff @(posedge clk) begin
		if (state_q == S_BOUNDS) begin
			lox_q <= lox;
			loy_q <= loy;
			hix_q <= MAP_AW'(hix);
			hiy_q <= MAP_AW'(hiy);
			ix_q  <= lox;
			jy_q  <= loy;
		end else if (state_q == S_RUN) begin
			if (jy_q == hiy_q) begin
				jy_q <= loy_q;
				ix_q <= ix_q + MAP_AW'(1);
			end else begin
				jy_q <= jy_q + MAP_AW'(1);
			end
		end
	end

	// map memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr.en)
			occ_mem[{wr.y, wr.x}] <= wr.val;
		bit_s1 <= occ_mem[{jy_q, ix_q}];
		ix_s1  <= ix_q;
		jy_s1  <= jy_q;
	end

	// multiply stage
	always_ff @(posedge clk) begin
		pxc_s2 <= dx * cw;
		pys_s2 <= dy * sw;
		pyc_s2 <= dy * cw;
		pxs_s2 <= dx * sw;
	end

	assign stat.done = done_q;
	assign stat.hit  = hit_q;
endmodule

[sv/oriented_footprint_grid_collision_core.sv]
`timescale 1ns / 1ps
// Footprint collision checker against a one-bit occupancy map.
// in_ch carries one word per request: a map write, a segment check or a pose check.
// out_ch returns one word (clear, midpoint_hit) per check; writes give none.
// The configuration port takes a register write on any edge with cfg_we high;
// write only while no check is in flight.
// Flow: a map write goes straight to the memory when accepted. A check runs a
// CORDIC for cos/sin, after a first CORDIC for the heading of a segment whose
// previous position differs from the current one, then scans one window cell
// per cycle; a segment scans up to two windows of (2*half_window+1)^2 cells,
// i.e. up to 2*65*65 cells at the largest window, all through the single map
// read port. A scan stops early on the first blocked cell in footprint.
// One request is worked on at a time; the next is taken once the result sits
// in the output register, so a stalled receiver holds back only after that.
// Reset restores the register defaults and empties the output register; the
// map content is undefined until written.
module oriented_footprint_grid_collision_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	fpgc_in_if.sink     in_ch,
	fpgc_out_if.source  out_ch
);
	import fpgc_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_VEC_GO, S_VEC_WAIT, S_ROT_GO, S_ROT_WAIT,
		S_SCAN_GO, S_SCAN_WAIT, S_OUT
	} state_t;

	state_t      state_q;
	logic [10:0] map_width_q, map_height_q;
	logic [5:0]  half_window_q;
	logic [15:0] length_limit_q, width_limit_q;
	logic [13:0] px_q, py_q, bx_q, by_q;
	logic [15:0] h_q;
	logic        mid_q, phase_mid_q;
	logic signed [TRIG_W-1:0] c_q, s_q;
	logic        out_v_q, clear_q, mid_hit_q;
	logic        res_clear_q, res_mid_q;
	logic        res_clear, res_mid;

	logic        accept;
	req_t        req;
	map_wr_t     wr;
	scan_cfg_t   scfg;
	scan_req_t   sreq;
	scan_stat_t  sstat;
	logic        cor_start, cor_done;
	logic signed [CW-1:0] cx0, cy0, cz0, cx, cy, cz;
	logic signed [14:0]   dxs, dys;
	logic signed [CW-1:0] dxw, dyw, cc_w, ss_w;
	logic signed [TRIG_W-1:0] cc, ss;
	logic [31:0] turn;

	assign accept = in_ch.valid && in_ch.ready;
	assign req = req_t'(in_ch.req_type);
	assign in_ch.ready = (state_q == S_IDLE);

	// map writes go straight to the memory
	always_comb begin
		wr.en  = accept && (req == REQ_WRITE);
		wr.x   = in_ch.cell_x;
		wr.y   = in_ch.cell_y;
		wr.val = in_ch.cell_blocked;
	end

	// effective settings
	always_comb begin
		scfg.w_eff = (map_width_q > 11'(MAP_SIDE_MAX)) ? 11'(MAP_SIDE_MAX) : map_width_q;
		scfg.h_eff = (map_height_q > 11'(MAP_SIDE_MAX)) ? 11'(MAP_SIDE_MAX) : map_height_q;
		scfg.span = (half_window_q > 6'(HALF_WINDOW_MAX)) ?
			11'(HALF_WINDOW_MAX << SUB_BITS) : 11'({half_window_q, SUB_BITS'(0)});
		scfg.lx = length_limit_q;
		scfg.ly = width_limit_q;
	end

	always_comb begin
		sreq.qx = phase_mid_q ? 15'(px_q) + 15'(bx_q) : {px_q, 1'b0};
		sreq.qy = phase_mid_q ? 15'(py_q) + 15'(by_q) : {py_q, 1'b0};
		sreq.c = c_q;
		sreq.s = s_q;
	end

	// CORDIC operands: heading vector, or rotation of the unit vector
	always_comb begin
		dxs = $signed({1'b0, px_q}) - $signed({1'b0, bx_q});
		dys = $signed({1'b0, py_q}) - $signed({1'b0, by_q});
		dxw = CW'(dxs) <<< 16;
		dyw = CW'(dys) <<< 16;
		cor_start = (state_q == S_VEC_GO) || (state_q == S_ROT_GO);
		if (state_q == S_VEC_GO) begin
			cx0 = dxs[14] ? -dxw : dxw;
			cy0 = dxs[14] ? -dyw : dyw;
			cz0 = dxs[14] ? CW'(36'sh080000000) : '0;
		end else begin
			cx0 = CORDIC_X0;
			cy0 = '0;
			cz0 = CW'({h_q[ANGLE_BITS-3:0], 16'b0});
		end
		turn = cz[31:0] + 32'h0000_8000;
	end

	// round to Q16 and clamp to one
	always_comb begin
		cc_w = (cx + CW'(8192)) >>> 14;
		ss_w = (cy + CW'(8192)) >>> 14;
		if (cc_w > CW'(65536)) cc = TRIG_W'(65536);
		else if (cc_w < -CW'(65536)) cc = -TRIG_W'(65536);
		else cc = TRIG_W'(cc_w);
		if (ss_w > CW'(65536)) ss = TRIG_W'(65536);
		else if (ss_w < -CW'(65536)) ss = -TRIG_W'(65536);
		else ss = TRIG_W'(ss_w);
	end

	always_comb begin
		res_clear = 1'b1;
		res_mid = 1'b0;
		if (sstat.hit) begin
			res_clear = 1'b0;
			res_mid = phase_mid_q;
		end
	end

	fpgc_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cor_start), .mode_rot(state_q == S_ROT_GO),
		.x0(cx0), .y0(cy0), .z0(cz0), .done(cor_done), .x(cx), .y(cy), .z(cz)
	);

	fpgc_scan u_scan (
		.clk(clk), .arst_n(arst_n), .wr(wr), .cfg(scfg),
		.start(state_q == S_SCAN_GO), .req(sreq), .stat(sstat)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q    <= 11'd1024;
			map_height_q   <= 11'd1024;
			half_window_q  <= 6'd16;
			length_limit_q <= 16'd256;
			width_limit_q  <= 16'd256;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_MAP_WIDTH: map_width_q <= cfg_data[10:0];
				REG_MAP_HEIGHT: map_height_q <= cfg_data[10:0];
				REG_HALF_WINDOW: half_window_q <= cfg_data[5:0];
				REG_LENGTH_LIMIT: length_limit_q <= cfg_data;
				REG_WIDTH_LIMIT: width_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// request sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_v_q     <= 1'b0;
			clear_q     <= 1'b0;
			mid_hit_q   <= 1'b0;
			res_clear_q <= 1'b0;
			res_mid_q   <= 1'b0;
			mid_q       <= 1'b0;
			phase_mid_q <= 1'b0;
			h_q         <= '0;
		end else begin
			// load the output word when the slot frees, drop it once taken
			if (state_q == S_OUT && (!out_v_q || out_ch.ready))
				out_v_q <= 1'b1;
			else if (out_ch.ready)
				out_v_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req == REQ_POSE) begin
							h_q     <= in_ch.heading;
							mid_q   <= 1'b0;
							state_q <= S_ROT_GO;
						end else if (req == REQ_SEGMENT) begin
							h_q   <= '0;
							mid_q <= in_ch.has_prev;
							if (in_ch.has_prev && !(in_ch.pos_x == in_ch.prev_x &&
								in_ch.pos_y == in_ch.prev_y))
								state_q <= S_VEC_GO;
							else
								state_q <= S_ROT_GO;
						end
					end
				end
				S_VEC_GO: state_q <= S_VEC_WAIT;
				S_VEC_WAIT: begin
					if (cor_done) begin
						h_q     <= turn[31:16];
						state_q <= S_ROT_GO;
					end
				end
				S_ROT_GO: state_q <= S_ROT_WAIT;
				S_ROT_WAIT: begin
					if (cor_done) begin
						phase_mid_q <= mid_q;
						state_q     <= S_SCAN_GO;
					end
				end
				S_SCAN_GO: state_q <= S_SCAN_WAIT;
				S_SCAN_WAIT: begin
					if (sstat.done) begin
						res_clear_q <= res_clear;
						res_mid_q   <= res_mid;
						if (phase_mid_q && !sstat.hit) begin
							phase_mid_q <= 1'b0;
							state_q     <= S_SCAN_GO;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_OUT: begin
					if (!out_v_q || out_ch.ready) begin
						clear_q   <= res_clear_q;
						mid_hit_q <= res_mid_q;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// hold operands; rotate cos/sin into the heading's quadrant
	always_ff @(posedge clk) begin
		if (accept) begin
			px_q <= in_ch.pos_x;
			py_q <= in_ch.pos_y;
			bx_q <= in_ch.prev_x;
			by_q <= in_ch.prev_y;
		end
		if (state_q == S_ROT_WAIT && cor_done) begin
			case (h_q[ANGLE_BITS-1:ANGLE_BITS-2])
				2'd0: begin c_q <= cc; s_q <= ss; end
				2'd1: begin c_q <= -ss; s_q <= cc; end
				2'd2: begin c_q <= -cc; s_q <= -ss; end
				default: begin c_q <= ss; s_q <= -cc; end
			endcase
		end
	end

	assign out_ch.valid = out_v_q;
	assign out_ch.clear = clear_q;
	assign out_ch.midpoint_hit = mid_hit_q;
endmodule

[test/fpgc_result_checker.sv]
`timescale 1ns / 1ps
module fpgc_result_checker
	import fpgc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	fpgc_in_if          in_w,
	fpgc_out_if         out_w,
	output int          errors,
	output int          pending
);

	typedef struct {
		logic clear;
		logic midpoint_hit;
	} verdict_t;

	// arctangent of 2^-k, full turn = 2^32
	localparam longint ATAN_TBL [0:19] = '{
		64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
		64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
		64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
		64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518
	};

	bit          occ [0:MAP_SIDE_MAX*MAP_SIDE_MAX-1];
	logic [10:0] cols, rows;
	logic [5:0]  hwin;
	logic [15:0] len_lim, wid_lim;
	verdict_t    verdict_q [$];

	assign pending = verdict_q.size();

	// rotation factors in Q16 for a heading of 2^16 per turn
	function automatic void rot_factors(input logic [15:0] h, output longint c,
		output longint s);
		longint x, y, z, xs, ys, cc, ss;
		logic [1:0] quad;
		x = 652032874;
		y = 0;
		quad = h[15:14];
		z = longint'(h[13:0]) <<< 16;
		for (int k = 0; k < 20; k++) begin
			xs = x >>> k;
			ys = y >>> k;
			if (z >= 0) begin
				x -= ys; y += xs; z -= ATAN_TBL[k];
			end else begin
				x += ys; y -= xs; z += ATAN_TBL[k];
			end
		end
		cc = (x + 8192) >>> 14;
		ss = (y + 8192) >>> 14;
		if (cc > 65536) cc = 65536;
		if (cc < -65536) cc = -65536;
		if (ss > 65536) ss = 65536;
		if (ss < -65536) ss = -65536;
		case (quad)
			2'd0: begin c = cc; s = ss; end
			2'd1: begin c = -ss; s = cc; end
			2'd2: begin c = -cc; s = -ss; end
			default: begin c = ss; s = -cc; end
		endcase
	endfunction

	// heading of the vector (dx, dy), vectoring mode
	function automatic logic [15:0] seg_heading(input longint dx, input longint dy);
		longint x, y, z, xs, ys;
		logic [31:0] turn;
		if (dx == 0 && dy == 0) return 16'd0;
		x = dx * 65536;
		y = dy * 65536;
		z = 0;
		if (x < 0) begin
			x = -x; y = -y; z = 64'sd1 <<< 31;
		end
		for (int k = 0; k < 20; k++) begin
			xs = x >>> k;
			ys = y >>> k;
			if (y > 0) begin
				x += ys; y -= xs; z += ATAN_TBL[k];
			end else begin
				x -= ys; y += xs; z -= ATAN_TBL[k];
			end
		end
		turn = z[31:0] + 32'd32768;
		return turn[31:16];
	endfunction

	// qx, qy in 1/32 cell
	function automatic bit footprint_free(input longint qx, input longint qy,
		input logic [15:0] h);
		longint w, ht, hw, span, lx, ly, lox, hix, loy, hiy, c, s, dx, dy, nx, ny;
		w = (cols > 1024) ? 1024 : cols;
		ht = (rows > 1024) ? 1024 : rows;
		hw = (hwin > 32) ? 32 : hwin;
		span = hw <<< 5;
		lx = longint'(len_lim) <<< 17;
		ly = longint'(wid_lim) <<< 17;
		if (w == 0 || ht == 0) return 1'b1;
		lox = qx - span; lox = (lox < 0) ? 0 : (lox >>> 5);
		loy = qy - span; loy = (loy < 0) ? 0 : (loy >>> 5);
		hix = (qx + span) >>> 5; if (hix > w - 1) hix = w - 1;
		hiy = (qy + span) >>> 5; if (hiy > ht - 1) hiy = ht - 1;
		rot_factors(h, c, s);
		for (longint i = lox; i <= hix; i++) begin
			for (longint j = loy; j <= hiy; j++) begin
				if (occ[j * MAP_SIDE_MAX + i]) begin
					dx = (i <<< 5) - qx;
					dy = (j <<< 5) - qy;
					nx = dx * c + dy * s;
					ny = dy * c - dx * s;
					if (nx < 0) nx = -nx;
					if (ny < 0) ny = -ny;
					if (nx < lx && ny < ly) return 1'b0;
				end
			end
		end
		return 1'b1;
	endfunction

	// track register writes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols <= 11'd1024;
			rows <= 11'd1024;
			hwin <= 6'd16;
			len_lim <= 16'd256;
			wid_lim <= 16'd256;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAP_WIDTH: cols <= cfg_data[10:0];
				REG_MAP_HEIGHT: rows <= cfg_data[10:0];
				REG_HALF_WINDOW: hwin <= cfg_data[5:0];
				REG_LENGTH_LIMIT: len_lim <= cfg_data;
				REG_WIDTH_LIMIT: wid_lim <= cfg_data;
				default: ;
			endcase
		end
	end

	// predict each accepted request word
	always @(posedge clk) begin
		longint px, py, bx, by;
		logic [15:0] h;
		verdict_t v;
		if (arst_n && in_w.valid && in_w.ready) begin
			px = in_w.pos_x; py = in_w.pos_y;
			bx = in_w.prev_x; by = in_w.prev_y;
			case (in_w.req_type)
				REQ_WRITE: occ[int'(in_w.cell_y) * MAP_SIDE_MAX + int'(in_w.cell_x)] =
					in_w.cell_blocked;
				REQ_SEGMENT, REQ_POSE: begin
					v.clear = 1'b1;
					v.midpoint_hit = 1'b0;
					h = 16'd0;
					if (in_w.req_type == REQ_POSE) begin
						h = in_w.heading;
					end else if (in_w.has_prev) begin
						h = seg_heading(px - bx, py - by);
						if (!footprint_free(px + bx, py + by, h)) begin
							v.clear = 1'b0;
							v.midpoint_hit = 1'b1;
						end
					end
					if (!v.midpoint_hit && !footprint_free(px * 2, py * 2, h))
						v.clear = 1'b0;
					verdict_q.push_back(v);
				end
				default: ;
			endcase
		end
	end

	// compare each result word with the oldest prediction
	always @(posedge clk) begin
		verdict_t v;
		if (!arst_n) begin
			errors = 0;
		end else if (out_w.valid && out_w.ready) begin
			if (verdict_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result word clear=%0b midpoint_hit=%0b",
						out_w.clear, out_w.midpoint_hit);
			end else begin
				v = verdict_q.pop_front();
				if (v.clear !== out_w.clear || v.midpoint_hit !== out_w.midpoint_hit) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected clear=%0b midpoint_hit=%0b, got %0b %0b",
							v.clear, v.midpoint_hit, out_w.clear, out_w.midpoint_hit);
				end
			end
		end
	end

endmodule

[test/oriented_footprint_grid_collision_core_test.sv]
`timescale 1ns / 1ps
module oriented_footprint_grid_collision_core_test;
	import fpgc_pkg::*;

	localparam int FILL_SIDE = 8;
	localparam longint CYCLE_LIMIT = 4000000;

	typedef struct {
		req_t        rt;
		logic [9:0]  cx, cy;
		logic        blk;
		logic [13:0] px, py, bx, by;
		logic        hp;
		logic [15:0] hd;
	} req_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;
	int          errors, pending;
	int          cur_w, cur_h, cur_hw;
	int          burst_left = 0;
	bit          hold_req = 0, hold_done = 0;
	longint      cyc = 0;

	fpgc_in_if  in_w();
	fpgc_out_if out_w();

	oriented_footprint_grid_collision_core dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_ch(in_w), .out_ch(out_w)
	);

	fpgc_result_checker chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_w(in_w), .out_w(out_w), .errors(errors),
		.pending(pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// stop a hung run
	initial begin
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc >= CYCLE_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// result receiver: free runs, random stalls, and one long hold-off
	initial begin
		int run_left;
		bit stall_mode;
		run_left = 0;
		stall_mode = 0;
		out_w.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				out_w.ready <= 1'b0;
				repeat (3000) @(posedge clk);
				hold_done = 1;
			end else begin
				if (run_left == 0) begin
					stall_mode = 1'($urandom_range(0, 1));
					run_left = int'($urandom_range(10, 200));
				end
				run_left--;
				out_w.ready <= stall_mode ? ($urandom_range(0, 2) == 0) : 1'b1;
			end
		end
	end

	task automatic send_word(input req_word_t w);
		in_w.req_type <= w.rt;
		in_w.cell_x <= w.cx;
		in_w.cell_y <= w.cy;
		in_w.cell_blocked <= w.blk;
		in_w.pos_x <= w.px;
		in_w.pos_y <= w.py;
		in_w.prev_x <= w.bx;
		in_w.prev_y <= w.by;
		in_w.has_prev <= w.hp;
		in_w.heading <= w.hd;
		in_w.valid <= 1'b1;
		do @(posedge clk); while (!in_w.ready);
		// end a burst, usually with a random gap
		if (burst_left == 0) begin
			burst_left = int'($urandom_range(1, 12));
			if ($urandom_range(0, 2) != 0) begin
				in_w.valid <= 1'b0;
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	function automatic req_word_t noise_word(input req_t rt);
		req_word_t w;
		w.rt = rt;
		w.cx = 10'($urandom); w.cy = 10'($urandom); w.blk = 1'($urandom);
		w.px = 14'($urandom); w.py = 14'($urandom);
		w.bx = 14'($urandom); w.by = 14'($urandom);
		w.hp = 1'($urandom); w.hd = 16'($urandom);
		return w;
	endfunction

	function automatic req_word_t query(input req_t rt, input int px, input int py,
		input int bx, input int by, input bit hp, input int hd);
		req_word_t w;
		w = noise_word(rt);
		w.px = 14'(px); w.py = 14'(py); w.bx = 14'(bx); w.by = 14'(by);
		w.hp = hp; w.hd = 16'(hd);
		return w;
	endfunction

	function automatic req_word_t cell_write(input int x, input int y, input bit b);
		req_word_t w;
		w = noise_word(REQ_WRITE);
		w.cx = 10'(x); w.cy = 10'(y); w.blk = b;
		return w;
	endfunction

	// position on one axis whose scan window only touches written cells
	function automatic int pick_axis(input int dim);
		int d, hw;
		d = (dim > 1024) ? 1024 : dim;
		hw = (cur_hw > 32) ? 32 : cur_hw;
		if (d > FILL_SIDE) return int'($urandom_range(0, (FILL_SIDE - hw) * 16 - 1));
		if ($urandom_range(0, 4) == 0) return int'($urandom_range(0, 16383));
		return int'($urandom_range(0, (d + hw) * 16 < 16383 ? (d + hw) * 16 : 16383));
	endfunction

	// wait for every result, then let a trailing map write settle
	task automatic drain();
		in_w.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic set_regs(input int w, input int h, input int hw, input int ll,
		input int wl);
		reg_idx_t idx [5];
		int val [5];
		idx = '{REG_MAP_WIDTH, REG_MAP_HEIGHT, REG_HALF_WINDOW, REG_LENGTH_LIMIT,
			REG_WIDTH_LIMIT};
		val = '{w, h, hw, ll, wl};
		for (int i = 0; i < 5; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= 16'(val[i]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
		cur_w = w; cur_h = h; cur_hw = hw;
	endtask

	initial begin
		req_word_t w;
		int sel, ax, ay;
		cfg_we <= 1'b0;
		cfg_index <= REG_MAP_WIDTH;
		cfg_data <= '0;
		in_w.valid <= 1'b0;
		in_w.req_type <= REQ_WRITE;
		in_w.cell_x <= '0; in_w.cell_y <= '0; in_w.cell_blocked <= 1'b0;
		in_w.pos_x <= '0; in_w.pos_y <= '0; in_w.prev_x <= '0; in_w.prev_y <= '0;
		in_w.has_prev <= 1'b0; in_w.heading <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// load the corner of the map that every scan stays within
		set_regs(FILL_SIDE, FILL_SIDE, 16, 256, 256);
		for (int y = 0; y < FILL_SIDE; y++)
			for (int x = 0; x < FILL_SIDE; x++)
				send_word(cell_write(x, y, $urandom_range(0, 3) == 0));
		drain();

		// directed: headings, segment shapes, edges of the written area
		send_word(query(REQ_POSE, 0, 0, 0, 0, 0, 0));
		send_word(query(REQ_POSE, 60, 60, 0, 0, 0, 65535));
		send_word(query(REQ_POSE, 64, 64, 0, 0, 0, 16384));
		send_word(query(REQ_POSE, 64, 64, 0, 0, 0, 32768));
		send_word(query(REQ_POSE, 100, 30, 0, 0, 0, 49152));
		send_word(query(REQ_SEGMENT, 80, 80, 0, 0, 0, 0));
		send_word(query(REQ_SEGMENT, 60, 60, 60, 60, 1, 0));
		send_word(query(REQ_SEGMENT, 100, 20, 20, 100, 1, 0));
		send_word(query(REQ_SEGMENT, 20, 127, 127, 0, 1, 0));
		send_word(cell_write(1023, 1023, 1));
		send_word(cell_write(1023, 0, 1));
		send_word(cell_write(0, 0, 0));
		w = noise_word(REQ_NONE);
		send_word(w);
		drain();
		// full-size map with a window that stays inside the written corner
		set_regs(1024, 1024, 2, 300, 120);
		send_word(query(REQ_POSE, 40, 50, 0, 0, 0, 1000));
		send_word(query(REQ_SEGMENT, 70, 20, 10, 80, 1, 0));
		drain();
		// largest window and limits; queries far past the map scan nothing
		set_regs(FILL_SIDE, FILL_SIDE, 32, 65535, 65535);
		send_word(query(REQ_POSE, 16383, 16383, 0, 0, 0, 12345));
		send_word(query(REQ_SEGMENT, 16383, 16383, 0, 0, 1, 0));
		send_word(query(REQ_SEGMENT, 70, 70, 80, 40, 1, 0));
		send_word(query(REQ_POSE, 0, 16383, 0, 0, 0, 0));
		drain();
		// zero width map, then a single cell with zero limits
		set_regs(0, 1, 0, 0, 0);
		send_word(query(REQ_POSE, 500, 500, 0, 0, 0, 0));
		drain();
		set_regs(1, 1, 0, 0, 0);
		send_word(query(REQ_POSE, 0, 0, 0, 0, 0, 0));
		send_word(query(REQ_SEGMENT, 8, 8, 0, 0, 1, 0));
		drain();
		// oversized registers saturate
		set_regs(2047, 2047, 0, 300, 120);
		send_word(query(REQ_POSE, 100, 50, 0, 0, 0, 1000));
		send_word(query(REQ_SEGMENT, 127, 127, 0, 0, 1, 0));
		drain();
		set_regs(FILL_SIDE, FILL_SIDE, 63, 300, 120);
		send_word(query(REQ_POSE, 512, 512, 0, 0, 0, 1000));
		drain();

		// random phases
		for (int ph = 0; ph < 3; ph++) begin
			int dims [2];
			int hw_sel;
			for (int a = 0; a < 2; a++) begin
				case ($urandom_range(0, 3))
					0: dims[a] = FILL_SIDE;
					1: dims[a] = int'($urandom_range(1, FILL_SIDE));
					2: dims[a] = 1024;
					default: dims[a] = 2047;
				endcase
			end
			if (dims[0] <= FILL_SIDE && dims[1] <= FILL_SIDE)
				hw_sel = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 63)) :
					int'($urandom_range(0, 8));
			else
				hw_sel = int'($urandom_range(0, FILL_SIDE - 2));
			set_regs(dims[0], dims[1], hw_sel,
				($urandom_range(0, 5) == 0) ? int'($urandom_range(0, 65535)) :
					int'($urandom_range(0, 600)),
				($urandom_range(0, 5) == 0) ? int'($urandom_range(0, 65535)) :
					int'($urandom_range(0, 600)));
			if (ph == 1) hold_req = 1;
			for (int n = 0; n < 18; n++) begin
				sel = int'($urandom_range(0, 19));
				if (sel < 4) begin
					if (sel < 2) w = cell_write(int'($urandom_range(0, FILL_SIDE - 1)),
						int'($urandom_range(0, FILL_SIDE - 1)), 1'($urandom));
					else w = noise_word(REQ_WRITE);
				end else if (sel == 4) begin
					w = noise_word(REQ_NONE);
				end else begin
					w = noise_word(sel < 12 ? REQ_SEGMENT : REQ_POSE);
					w.px = 14'(pick_axis(cur_w));
					w.py = 14'(pick_axis(cur_h));
					w.bx = 14'(pick_axis(cur_w));
					w.by = 14'(pick_axis(cur_h));
					// short segments now and then
					if ($urandom_range(0, 3) == 0) begin
						ax = int'(w.px) + int'($urandom_range(0, 64)) - 32;
						ay = int'(w.py) + int'($urandom_range(0, 64)) - 32;
						if (ax >= 0 && ay >= 0 && ax <= int'(w.px) && ay <= int'(w.py)) begin
							w.bx = 14'(ax); w.by = 14'(ay);
						end
					end
				end
				send_word(w);
			end
			drain();
		end

		repeat (200) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
